// ===== src/plti_pkg.sv =====
// ----------------------------------------------------------------------------
// plti_pkg
// Shared types and constants of the piecewise linear table interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int KEY_W  = 16;
    localparam int VAL_W  = 32;
    localparam int DIFF_W = VAL_W + 1;
    localparam int DX_W   = KEY_W + 1;
    localparam int PROD_W = DIFF_W + DX_W;
    localparam int MAG_W  = PROD_W - 1;
    localparam int DCNT_W = $clog2(MAG_W + 1);
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        RA_LAST,
        RA_ZERO,
        RA_MID,
        RA_A,
        RA_LO
    } t_rd_sel;

    typedef enum logic [2:0] {
        RES_HOLD,
        RES_ZERO,
        RES_MEM,
        RES_A,
        RES_LERP
    } t_res_sel;

    typedef struct packed {
        logic     latch_in;
        logic     exec;
        t_rd_sel  rd_sel;
        logic     srch_init;
        logic     srch_mid;
        logic     srch_step;
        logic     cap_a;
        logic     cap_diff;
        logic     mul;
        logic     div_start;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            cnt_zero;
        logic            x_gt;
        logic            x_lt;
        logic            srch_done;
        logic            lo_zero;
        logic            kb_le_ka;
        logic            div_busy;
    } t_sts;

endpackage

// ===== src/piecewise_linear_table_interp_unit.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp_unit
// Breakpoint table with load, clear and linear interpolation query.
// ----------------------------------------------------------------------------
// One item is in work at a time; a new item is taken while the previous
// result still waits in the output register. Load, clear, no-op and a query
// on an empty table go straight to the result; an out-of-range query is
// answered from the last or first entry; an interpolating query adds a
// binary search over the single-read-port key memory and a bit-serial
// divider that forms the fraction. Keys must be loaded in ascending order
// for a meaningful result.
module piecewise_linear_table_interp_unit #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [plti_pkg::OP_W-1:0]          i_opcode,
    input  logic [plti_pkg::KEY_W-1:0]         i_mole_fraction,
    input  logic signed [plti_pkg::VAL_W-1:0]  i_enthalpy_in,
    input  logic signed [plti_pkg::VAL_W-1:0]  i_entropy_in,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [plti_pkg::VAL_W-1:0]  o_enthalpy_out,
    output logic signed [plti_pkg::VAL_W-1:0]  o_entropy_out,
    output logic [plti_pkg::ST_W-1:0]          o_status
);

    plti_pkg::t_cmd cmd;
    plti_pkg::t_sts sts;

    plti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    plti_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_opcode        (i_opcode),
        .i_mole_fraction (i_mole_fraction),
        .i_enthalpy_in   (i_enthalpy_in),
        .i_entropy_in    (i_entropy_in),
        .o_enthalpy_out  (o_enthalpy_out),
        .o_entropy_out   (o_entropy_out),
        .o_status        (o_status)
    );

endmodule

// ===== src/plti_div.sv =====
// ----------------------------------------------------------------------------
// plti_div
// Radix-2 restoring divider, signed dividend by unsigned key span,
// quotient truncated toward zero.
// ----------------------------------------------------------------------------
module plti_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [plti_pkg::PROD_W-1:0]  i_dividend,
    input  logic        [plti_pkg::KEY_W-1:0]   i_divisor,
    output logic                                o_busy,
    output logic signed [plti_pkg::PROD_W-1:0]  o_quotient
);

    logic [plti_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic [plti_pkg::MAG_W-1:0]  r_q, n_q;
    logic [plti_pkg::KEY_W-1:0]  r_rem, n_rem;
    logic [plti_pkg::KEY_W-1:0]  r_dvs, n_dvs;
    logic                        r_neg, n_neg;
    logic [plti_pkg::KEY_W:0]    rem_sh;
    logic [plti_pkg::KEY_W:0]    rem_sub;
    logic [plti_pkg::PROD_W-1:0] dvd_abs;

    assign dvd_abs = i_dividend[plti_pkg::PROD_W-1] ? -i_dividend : i_dividend;
    assign rem_sh  = {r_rem, r_q[plti_pkg::MAG_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_cnt = r_cnt;
        n_q   = r_q;
        n_rem = r_rem;
        n_dvs = r_dvs;
        n_neg = r_neg;
        if (i_start) begin
            n_cnt = plti_pkg::DCNT_W'(plti_pkg::MAG_W);
            n_q   = dvd_abs[plti_pkg::MAG_W-1:0];
            n_rem = '0;
            n_dvs = i_divisor;
            n_neg = i_dividend[plti_pkg::PROD_W-1];
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            if (rem_sh >= {1'b0, r_dvs}) begin
                n_rem = rem_sub[plti_pkg::KEY_W-1:0];
                n_q   = {r_q[plti_pkg::MAG_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[plti_pkg::KEY_W-1:0];
                n_q   = {r_q[plti_pkg::MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_neg <= n_neg;
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule

// ===== src/plti_dp.sv =====
// ----------------------------------------------------------------------------
// plti_dp
// Breakpoint memories, search registers, interpolation arithmetic and
// output registers.
// ----------------------------------------------------------------------------
module plti_dp #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  plti_pkg::t_cmd                     i_cmd,
    output plti_pkg::t_sts                     o_sts,
    input  logic [plti_pkg::OP_W-1:0]          i_opcode,
    input  logic [plti_pkg::KEY_W-1:0]         i_mole_fraction,
    input  logic signed [plti_pkg::VAL_W-1:0]  i_enthalpy_in,
    input  logic signed [plti_pkg::VAL_W-1:0]  i_entropy_in,
    output logic signed [plti_pkg::VAL_W-1:0]  o_enthalpy_out,
    output logic signed [plti_pkg::VAL_W-1:0]  o_entropy_out,
    output logic [plti_pkg::ST_W-1:0]          o_status
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    logic [plti_pkg::KEY_W-1:0]        mem_key [TABLE_ENTRIES];
    logic signed [plti_pkg::VAL_W-1:0] mem_h   [TABLE_ENTRIES];
    logic signed [plti_pkg::VAL_W-1:0] mem_s   [TABLE_ENTRIES];

    logic [plti_pkg::OP_W-1:0]         r_op;
    logic [plti_pkg::KEY_W-1:0]        r_x;
    logic signed [plti_pkg::VAL_W-1:0] r_h_in, r_s_in;
    logic [CW-1:0]                     r_count, n_count;
    logic [CW-1:0]                     r_lo, r_hi, r_mid;
    logic [plti_pkg::KEY_W-1:0]        r_rd_key, r_ka;
    logic signed [plti_pkg::VAL_W-1:0] r_rd_h, r_rd_s, r_ha, r_sa;
    logic signed [plti_pkg::DIFF_W-1:0] r_dh, r_ds;
    logic signed [plti_pkg::DX_W-1:0]  r_dx;
    logic [plti_pkg::KEY_W-1:0]        r_dk;
    logic signed [plti_pkg::PROD_W-1:0] r_ph, r_ps;
    logic signed [plti_pkg::VAL_W-1:0] r_res_h, r_res_s;
    logic [plti_pkg::ST_W-1:0]         r_res_st;
    logic signed [plti_pkg::VAL_W-1:0] r_out_h, r_out_s;
    logic [plti_pkg::ST_W-1:0]         r_out_st;

    logic [IW-1:0]                     raddr;
    logic [CW:0]                       lo_hi_sum;
    logic [CW-1:0]                     mid;
    logic [CW-1:0]                     lo_eff;
    logic                              full;
    logic signed [plti_pkg::PROD_W-1:0] q_h, q_s;
    logic                              busy_h, busy_s;
    logic signed [plti_pkg::VAL_W-1:0] sat_h, sat_s;

    function automatic logic signed [plti_pkg::VAL_W-1:0] sat_add(
        input logic signed [plti_pkg::VAL_W-1:0]  base,
        input logic signed [plti_pkg::PROD_W-1:0] q
    );
        logic signed [plti_pkg::SUM_W-1:0] sum;
        logic signed [plti_pkg::SUM_W-1:0] vmax;
        logic signed [plti_pkg::SUM_W-1:0] vmin;
        vmax = plti_pkg::SUM_W'({1'b0, {(plti_pkg::VAL_W-1){1'b1}}});
        vmin = -vmax - plti_pkg::SUM_W'(1);
        sum  = plti_pkg::SUM_W'(base) + plti_pkg::SUM_W'(q);
        if (sum > vmax) begin
            return vmax[plti_pkg::VAL_W-1:0];
        end else if (sum < vmin) begin
            return vmin[plti_pkg::VAL_W-1:0];
        end
        return sum[plti_pkg::VAL_W-1:0];
    endfunction

    assign full      = (r_count >= CW'(TABLE_ENTRIES));
    assign lo_hi_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = lo_hi_sum[CW:1];
    // the search can run past the end on unsorted tables
    assign lo_eff    = (r_lo >= r_count) ? r_count - 1'b1 : r_lo;

    always_comb begin
        case (i_cmd.rd_sel)
            plti_pkg::RA_LAST: raddr = IW'(r_count - 1'b1);
            plti_pkg::RA_ZERO: raddr = '0;
            plti_pkg::RA_MID:  raddr = IW'(mid);
            plti_pkg::RA_A:    raddr = (lo_eff == '0) ? '0 : IW'(lo_eff - 1'b1);
            plti_pkg::RA_LO:   raddr = IW'(lo_eff);
            default:           raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && r_op == plti_pkg::OP_LOAD && !full) begin
            mem_key[IW'(r_count)] <= r_x;
            mem_h[IW'(r_count)]   <= r_h_in;
            mem_s[IW'(r_count)]   <= r_s_in;
        end
        r_rd_key <= mem_key[raddr];
        r_rd_h   <= mem_h[raddr];
        r_rd_s   <= mem_s[raddr];
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.exec) begin
            if (r_op == plti_pkg::OP_LOAD && !full) begin
                n_count = r_count + 1'b1;
            end else if (r_op == plti_pkg::OP_CLEAR) begin
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op   <= i_opcode;
            r_x    <= i_mole_fraction;
            r_h_in <= i_enthalpy_in;
            r_s_in <= i_entropy_in;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.srch_step) begin
            if (r_rd_key < r_x) begin
                r_lo <= r_mid + 1'b1;
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.srch_mid) begin
            r_mid <= mid;
        end
        if (i_cmd.cap_a) begin
            r_ka <= r_rd_key;
            r_ha <= r_rd_h;
            r_sa <= r_rd_s;
        end
        if (i_cmd.cap_diff) begin
            r_dh <= plti_pkg::DIFF_W'(r_rd_h) - plti_pkg::DIFF_W'(r_ha);
            r_ds <= plti_pkg::DIFF_W'(r_rd_s) - plti_pkg::DIFF_W'(r_sa);
            r_dx <= $signed({1'b0, r_x}) - $signed({1'b0, r_ka});
            r_dk <= r_rd_key - r_ka;
        end
        if (i_cmd.mul) begin
            r_ph <= r_dh * r_dx;
            r_ps <= r_ds * r_dx;
        end
        case (i_cmd.res_sel)
            plti_pkg::RES_ZERO: begin
                r_res_h  <= '0;
                r_res_s  <= '0;
                if (r_op == plti_pkg::OP_QUERY && r_count == '0) begin
                    r_res_st <= plti_pkg::ST_EMPTY;
                end else if (r_op == plti_pkg::OP_LOAD && full) begin
                    r_res_st <= plti_pkg::ST_FULL;
                end else begin
                    r_res_st <= plti_pkg::ST_OK;
                end
            end
            plti_pkg::RES_MEM: begin
                r_res_h <= r_rd_h;
                r_res_s <= r_rd_s;
            end
            plti_pkg::RES_A: begin
                r_res_h <= r_ha;
                r_res_s <= r_sa;
            end
            plti_pkg::RES_LERP: begin
                r_res_h <= sat_h;
                r_res_s <= sat_s;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_h  <= r_res_h;
            r_out_s  <= r_res_s;
            r_out_st <= r_res_st;
        end
    end

    plti_div u_div_h (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_ph),
        .i_divisor  (r_dk),
        .o_busy     (busy_h),
        .o_quotient (q_h)
    );

    plti_div u_div_s (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_ps),
        .i_divisor  (r_dk),
        .o_busy     (busy_s),
        .o_quotient (q_s)
    );

    assign sat_h = sat_add(r_ha, q_h);
    assign sat_s = sat_add(r_sa, q_s);

    assign o_sts.op        = r_op;
    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.x_gt      = (r_x > r_rd_key);
    assign o_sts.x_lt      = (r_x < r_rd_key);
    assign o_sts.srch_done = (r_lo >= r_hi);
    assign o_sts.lo_zero   = (lo_eff == '0);
    assign o_sts.kb_le_ka  = (r_rd_key <= r_ka);
    assign o_sts.div_busy  = busy_h | busy_s;

    assign o_enthalpy_out = r_out_h;
    assign o_entropy_out  = r_out_s;
    assign o_status       = r_out_st;

endmodule

// ===== src/plti_ctrl.sv =====
// ----------------------------------------------------------------------------
// plti_ctrl
// Sequencer for decode, range checks, binary search and interpolation.
// ----------------------------------------------------------------------------
module plti_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  plti_pkg::t_sts i_sts,
    output plti_pkg::t_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE      = 12'b0000_0000_0001,
        S_DECODE    = 12'b0000_0000_0010,
        S_RD_LAST   = 12'b0000_0000_0100,
        S_CHK_LAST  = 12'b0000_0000_1000,
        S_CHK_FIRST = 12'b0000_0001_0000,
        S_SRCH_RD   = 12'b0000_0010_0000,
        S_SRCH_CMP  = 12'b0000_0100_0000,
        S_RD_B      = 12'b0000_1000_0000,
        S_CALC      = 12'b0001_0000_0000,
        S_MUL       = 12'b0010_0000_0000,
        S_DIV       = 12'b0100_0000_0000,
        S_FIN       = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;
    logic   div_go, n_div_go, r_div_go;

    assign div_go = r_div_go;

    always_comb begin
        n_state  = r_state;
        n_div_go = 1'b0;
        o_cmd    = '0;
        o_cmd.rd_sel  = plti_pkg::RA_ZERO;
        o_cmd.res_sel = plti_pkg::RES_HOLD;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.exec    = 1'b1;
                o_cmd.res_sel = plti_pkg::RES_ZERO;
                if (i_sts.op == plti_pkg::OP_QUERY && !i_sts.cnt_zero) begin
                    n_state = S_RD_LAST;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD_LAST: begin
                o_cmd.rd_sel = plti_pkg::RA_LAST;
                n_state = S_CHK_LAST;
            end
            S_CHK_LAST: begin
                o_cmd.rd_sel = plti_pkg::RA_ZERO;
                if (i_sts.x_gt) begin
                    o_cmd.res_sel = plti_pkg::RES_MEM;
                    n_state = S_FIN;
                end else begin
                    n_state = S_CHK_FIRST;
                end
            end
            S_CHK_FIRST: begin
                if (i_sts.x_lt) begin
                    o_cmd.res_sel = plti_pkg::RES_MEM;
                    n_state = S_FIN;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_SRCH_RD: begin
                if (i_sts.srch_done) begin
                    o_cmd.rd_sel = plti_pkg::RA_A;
                    n_state = S_RD_B;
                end else begin
                    o_cmd.rd_sel   = plti_pkg::RA_MID;
                    o_cmd.srch_mid = 1'b1;
                    n_state = S_SRCH_CMP;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.srch_step = 1'b1;
                n_state = S_SRCH_RD;
            end
            S_RD_B: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_sel = plti_pkg::RA_LO;
                n_state = S_CALC;
            end
            S_CALC: begin
                // first entry, or equal or falling neighbors: lower entry wins
                if (i_sts.lo_zero || i_sts.kb_le_ka) begin
                    o_cmd.res_sel = plti_pkg::RES_A;
                    n_state = S_FIN;
                end else begin
                    o_cmd.cap_diff = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_div_go  = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_start = div_go;
                if (!div_go && !i_sts.div_busy) begin
                    o_cmd.res_sel = plti_pkg::RES_LERP;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_valid || i_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_valid = r_valid;
        if (o_cmd.out_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_valid  <= n_valid;
            r_div_go <= n_div_go;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

endmodule

// ===== src/plti_chk.sv =====
// ----------------------------------------------------------------------------
// plti_chk
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module plti_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [plti_pkg::VAL_W-1:0]  o_enthalpy_out,
    input logic signed [plti_pkg::VAL_W-1:0]  o_entropy_out,
    input logic [plti_pkg::ST_W-1:0]          o_status
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_enthalpy_out)
            && $stable(o_entropy_out) && $stable(o_status))
        else $error("result changed while stalled");

    // error answers carry zero values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != plti_pkg::ST_OK |-> o_enthalpy_out == '0
            && o_entropy_out == '0)
        else $error("nonzero values with error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == plti_pkg::ST_OK || o_status == plti_pkg::ST_EMPTY
            || o_status == plti_pkg::ST_FULL)
        else $error("undefined status code");

    // one item in work: busy right after a transfer in
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item taken while busy");

endmodule

bind piecewise_linear_table_interp_unit plti_chk u_plti_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_enthalpy_out (o_enthalpy_out),
    .o_entropy_out  (o_entropy_out),
    .o_status       (o_status)
);
